/* src/u128_divider_unit_defines.svh */
// Assertion macros for the 128-bit divider.
`ifndef U128_DIVIDER_UNIT_DEFINES_SVH
`define U128_DIVIDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/u128div_pkg.sv */
// Types and constants of the 128-bit divider.
package u128div_pkg;

    localparam int unsigned HALF_W = 64;
    localparam int unsigned WORD_W = 2 * HALF_W;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } state_t;

endpackage

/* src/u128_divider_unit.sv */
// Unsigned 128-bit divider: one 129-bit trial subtract per cycle while busy, one quotient bit
// a step; the final step stalls on an unclaimed result. Each request runs 128 subtract steps.
// A new request is taken only while the unit is idle (in_ready high), not during a division.
// A finished result sits in its own output register, so a new request is taken while it waits.
// The step loop around the shared 129-bit subtractor sets the rate.
// Reset (rst_n low, async) clears the sequencer and the output valid flag; no data is cleared.
`include "u128_divider_unit_defines.svh"

module u128_divider_unit
    import u128div_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HALF_W-1:0]   dividend_hi,
    input  logic [HALF_W-1:0]   dividend_lo,
    input  logic [HALF_W-1:0]   divisor_hi,
    input  logic [HALF_W-1:0]   divisor_lo,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [HALF_W-1:0]   quotient_hi,
    output logic [HALF_W-1:0]   quotient_lo,
    output logic [HALF_W-1:0]   remainder_hi,
    output logic [HALF_W-1:0]   remainder_lo,
    output logic                divide_by_zero
);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Working registers: partial remainder, dividend shifting into quotient, divisor
    logic [WORD_W-1:0]  rem_reg;
    logic [WORD_W-1:0]  quo_reg;
    logic [WORD_W-1:0]  div_reg;
    logic               dz_reg;

    // Result holding registers
    logic [WORD_W-1:0]  q_out_reg;
    logic [WORD_W-1:0]  r_out_reg;
    logic               dz_out_reg;

    logic               in_fire;
    logic               out_free;
    logic               last_step;
    logic               step_en;
    logic               load_out;

    // Shared datapath: shift in the next dividend bit and try the subtract
    logic [WORD_W:0]    shifted;
    logic [WORD_W+1:0]  diff;
    logic               take;
    logic [WORD_W-1:0]  rem_step;
    logic [WORD_W-1:0]  quo_step;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_step = (cnt_reg == CNT_LAST);

    assign shifted  = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, div_reg};
    // No borrow out of the 130-bit difference means the shifted remainder >= divisor
    assign take     = !diff[WORD_W+1];
    assign rem_step = take ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    assign quo_step = {quo_reg[WORD_W-2:0], take};

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                // Final step waits while the previous result is still unclaimed
                if (last_step && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        step_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_BUSY:
            begin
                step_en  = !last_step || out_free;
                load_out = last_step && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_fire)
        begin
            cnt_next = '0;
        end
        else if (step_en && !last_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rem_reg <= '0;
            quo_reg <= {dividend_hi, dividend_lo};
            div_reg <= {divisor_hi, divisor_lo};
            dz_reg  <= ({divisor_hi, divisor_lo} == '0);
        end
        else if (step_en)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    // Zero divisor forces a zero quotient and remainder
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            q_out_reg  <= dz_reg ? '0 : quo_step;
            r_out_reg  <= dz_reg ? '0 : rem_step;
            dz_out_reg <= dz_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quotient_hi    = q_out_reg[WORD_W-1:HALF_W];
    assign quotient_lo    = q_out_reg[HALF_W-1:0];
    assign remainder_hi   = r_out_reg[WORD_W-1:HALF_W];
    assign remainder_lo   = r_out_reg[HALF_W-1:0];
    assign divide_by_zero = dz_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // An accepted request always starts at step zero
    `ASSERT_NEXT(a_start_step, clk, rst_n, in_fire, (state_reg == ST_BUSY) && (cnt_reg == '0))
    // The step loop only pauses when an unclaimed result blocks the final step
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, (state_reg == ST_BUSY) && !step_en, out_valid_reg && last_step)
    // A divide-by-zero result carries all-zero data
    `ASSERT_IMPLY(a_dz_zero, clk, rst_n, out_valid_reg && dz_out_reg, (q_out_reg == '0) && (r_out_reg == '0))

endmodule
